@@ design/mmal_pkg.sv @@
// Package for the min/max auto-level block.
// Holds the operation codes and the result kind codes.
// No dependencies.
`default_nettype none

package mmal_pkg;

  typedef logic [1:0] op_t;

  localparam op_t OP_MEASURE = 2'd0;
  localparam op_t OP_REMAP   = 2'd1;
  localparam op_t OP_LOAD    = 2'd2;
  localparam op_t OP_NONE    = 2'd3;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_LEVEL = 2'd0;
  localparam kind_t KIND_PASS  = 2'd1;
  localparam kind_t KIND_ERROR = 2'd2;

endpackage

`default_nettype wire

@@ design/mmal_div.sv @@
// Restoring radix-2 divider for the auto-level block, one quotient bit per cycle.
// Requires dividend < divisor; returns the QUOT_BITS-bit fraction of their ratio.
// No package dependencies.
`default_nettype none

module mmal_div #(
  parameter int OPER_BITS = 16,
  parameter int QUOT_BITS = 16
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  input  wire [OPER_BITS-1:0]  dividend,
  input  wire [OPER_BITS-1:0]  divisor,
  output logic                 done,
  output logic [QUOT_BITS-1:0] quotient
);

  localparam int CNT_W = $clog2(QUOT_BITS + 1);

  logic [OPER_BITS-1:0] rem;
  logic [OPER_BITS-1:0] div_r;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic [OPER_BITS:0]   shifted;
  logic [OPER_BITS:0]   trial;
  logic                 fits;

  assign shifted = {rem, 1'b0};
  assign trial   = shifted - {1'b0, div_r};
  assign fits    = shifted >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUOT_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      div_r    <= divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= fits ? trial[OPER_BITS-1:0] : shifted[OPER_BITS-1:0];
      quotient <= {quotient[QUOT_BITS-2:0], fits};
    end
  end

endmodule

`default_nettype wire

@@ design/min_max_auto_level.sv @@
// Min/max auto-level: measure, load range, remap to Q.FRACTION_BITS (or bipolar).
// Measure, load and unused operations: one pass through the execute state, then ready again.
// Remap: divided case passes through the execute, bit-serial divider and output states;
// clamped, pass-through and error cases go from execute straight to the output state.
// Synchronous reset clears the range (invalid), bipolar_mode and the output valid.
`default_nettype none

module min_max_auto_level #(
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 16
) (
  input  wire clk,
  input  wire rst,

  input  wire cfg_we,
  input  wire cfg_wdata,

  input  wire                                       s_tvalid,
  output logic                                      s_tready,
  // sample, range_low, range_high
  input  wire [((3*SAMPLE_BITS+7)/8)*8-1:0]         s_tdata,
  // operation[1:0], first
  input  wire [2:0]                                 s_tuser,

  output logic                                      m_tvalid,
  input  wire                                       m_tready,
  // level
  output logic [((FRACTION_BITS+2+7)/8)*8-1:0]      m_tdata,
  // passed_through, status
  output logic [1:0]                                m_tuser
);

  localparam int SB    = SAMPLE_BITS;
  localparam int FB    = FRACTION_BITS;
  localparam int LB    = FRACTION_BITS + 2;
  localparam int OUT_W = ((LB + 7) / 8) * 8;
  localparam int EXT_W = (SB > LB) ? SB : LB;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_OUT  = 3'd3;

  logic [2:0] state;

  logic                   bipolar_mode;
  logic signed [SB-1:0]   range_min;
  logic signed [SB-1:0]   range_max;
  logic                   range_valid;

  mmal_pkg::op_t          op_r;
  logic signed [SB-1:0]   sample_r;
  logic                   first_r;
  logic signed [SB-1:0]   low_r;
  logic signed [SB-1:0]   high_r;

  mmal_pkg::kind_t        res_kind;
  logic [FB:0]            res_n;

  logic [SB-1:0]          diff;
  logic [SB-1:0]          span;
  logic                   div_start;
  logic                   div_done;
  logic [FB-1:0]          div_quot;
  logic                   out_load;

  logic signed [EXT_W-1:0] sample_ext;
  logic [LB-1:0]           level;

  // differences are nonnegative and below 2**SB when the divider runs
  assign s_tready   = (state == ST_IDLE);
  assign diff       = sample_r - range_min;
  assign span       = range_max - range_min;
  assign sample_ext = EXT_W'(sample_r);
  assign out_load   = (state == ST_OUT) && (!m_tvalid || m_tready);

  assign div_start = (state == ST_EXEC) && (op_r == mmal_pkg::OP_REMAP) && range_valid &&
                     (range_max != range_min) && (sample_r > range_min) &&
                     (sample_r < range_max);

  mmal_div #(
    .OPER_BITS (SB),
    .QUOT_BITS (FB)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (diff),
    .divisor  (span),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    case (res_kind)
      mmal_pkg::KIND_PASS:  level = sample_ext[LB-1:0];
      mmal_pkg::KIND_ERROR: level = '0;
      default: begin
        if (bipolar_mode) begin
          level = {res_n, 1'b0} - (LB'(1) << FB);
        end else begin
          level = LB'(res_n);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_r     <= s_tuser[1:0];
      first_r  <= s_tuser[2];
      sample_r <= s_tdata[SB-1:0];
      low_r    <= s_tdata[2*SB-1:SB];
      high_r   <= s_tdata[3*SB-1:2*SB];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      bipolar_mode <= 1'b0;
      range_min    <= '0;
      range_max    <= '0;
      range_valid  <= 1'b0;
      m_tvalid     <= 1'b0;
      res_kind     <= mmal_pkg::KIND_LEVEL;
    end else begin
      if (cfg_we) begin
        bipolar_mode <= cfg_wdata;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          case (op_r)
            mmal_pkg::OP_MEASURE: begin
              state <= ST_IDLE;
              if (first_r || !range_valid) begin
                range_min   <= sample_r;
                range_max   <= sample_r;
                range_valid <= 1'b1;
              end else begin
                if (sample_r < range_min) range_min <= sample_r;
                if (sample_r > range_max) range_max <= sample_r;
              end
            end
            mmal_pkg::OP_LOAD: begin
              state       <= ST_IDLE;
              range_min   <= low_r;
              range_max   <= high_r;
              range_valid <= (high_r >= low_r);
            end
            mmal_pkg::OP_REMAP: begin
              if (!range_valid) begin
                res_kind <= mmal_pkg::KIND_ERROR;
                state    <= ST_OUT;
              end else if (range_max == range_min) begin
                res_kind <= mmal_pkg::KIND_PASS;
                state    <= ST_OUT;
              end else if (sample_r <= range_min) begin
                res_kind <= mmal_pkg::KIND_LEVEL;
                res_n    <= '0;
                state    <= ST_OUT;
              end else if (sample_r >= range_max) begin
                res_kind <= mmal_pkg::KIND_LEVEL;
                res_n    <= (FB+1)'(1) << FB;
                state    <= ST_OUT;
              end else begin
                res_kind <= mmal_pkg::KIND_LEVEL;
                state    <= ST_DIV;
              end
            end
            default: begin
              state <= ST_IDLE;
            end
          endcase
        end
        ST_DIV: begin
          if (div_done) begin
            res_n <= {1'b0, div_quot};
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            m_tdata  <= OUT_W'(level);
            m_tuser  <= {res_kind == mmal_pkg::KIND_ERROR, res_kind == mmal_pkg::KIND_PASS};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
